// ===== rtl/core/ptp_pkg.sv =====
// shared types and constants of the palette text parser
package ptp_pkg;

   // parse phases
   localparam logic [2:0] PH_SIG   = 3'd0;
   localparam logic [2:0] PH_VER   = 3'd1;
   localparam logic [2:0] PH_COUNT = 3'd2;
   localparam logic [2:0] PH_COLOR = 3'd3;
   localparam logic [2:0] PH_DONE  = 3'd4;
   localparam logic [2:0] PH_HALT  = 3'd5;

   // number field phases
   localparam logic [1:0] FP_START  = 2'd0;
   localparam logic [1:0] FP_SIGN   = 2'd1;
   localparam logic [1:0] FP_DIGITS = 2'd2;

   // field number once the last field of a line has been closed
   localparam logic [1:0] FIELD_DONE = 2'd3;

   // result status codes
   localparam logic [2:0] ST_COLOR       = 3'd0;
   localparam logic [2:0] ST_HDR_READ    = 3'd1;
   localparam logic [2:0] ST_BAD_SIG     = 3'd2;
   localparam logic [2:0] ST_BAD_VER     = 3'd3;
   localparam logic [2:0] ST_BAD_COUNT   = 3'd4;
   localparam logic [2:0] ST_BAD_CHANNEL = 3'd5;

   // special characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_EOF   = 8'hFF;

   localparam int SIG_LEN = 8;
   localparam int VER_LEN = 4;
   localparam int CHANNEL_LIMIT = 255;

   // signature line text, first character at index 0
   localparam logic [7:0] SIG_TEXT [SIG_LEN] = '{
      8'h4A, 8'h41, 8'h53, 8'h43, 8'h2D, 8'h50, 8'h41, 8'h4C
   };

   // version line text
   localparam logic [7:0] VER_TEXT [VER_LEN] = '{8'h30, 8'h31, 8'h30, 8'h30};

   // one result beat
   typedef struct packed {
      logic [2:0] status;
      logic [7:0] color_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last_color;
   } rsp_type;

endpackage

// ===== rtl/core/palette_text_parser.sv =====
// palette text parser: byte stream in, one beat per color or error out
//
// channel  dir  tdata                         tuser                tlast
// req      in   [7:0] data_byte               [0] start_of_file    end_of_input
// rsp      out  [7:0] color_index [15:8] red  [2:0] status         last_color
//               [23:16] green [31:24] blue
// csr      -    none
//
// one byte beat per cycle sustained while the result is not stalled; a beat waits in the
// input register and its result, if any, loads into the result register when it drains
// the per-byte path is one compare set plus one multiply-by-ten add on the field
// reset is synchronous and active high; it clears the pipeline valids and parser state
// a stalled result holds the result register; the input register still takes a
// beat as long as it drains, so req_tready falls only when both stages are full
// and the result is stalled
module palette_text_parser #(
   parameter int MAX_LINE_CHARS = 15,
   parameter int MAX_COLORS     = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] start_of_file
   input  logic        req_tlast,   // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] color_index, [15:8] red, [23:16] green, [31:24] blue
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic        rsp_tlast    // last_color
);

   // line length counter holds up to the limit itself
   localparam int LW = $clog2(MAX_LINE_CHARS + 1);
   // color counters hold up to the declared count
   localparam int CW = $clog2(MAX_COLORS + 1);
   // field value width holds the larger of the count and channel limits
   localparam int FMAX = (MAX_COLORS > ptp_pkg::CHANNEL_LIMIT) ? MAX_COLORS
                                                               : ptp_pkg::CHANNEL_LIMIT;
   localparam int FVW = $clog2(FMAX + 1);
   // room for value * 10 + 9
   localparam int PW = FVW + 4;
   localparam int IXW = (CW > 8) ? CW : 8;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eoi_ff;
   logic       in_sof_ff;

   // result register
   logic              rsp_valid_ff;
   ptp_pkg::rsp_type  rsp_ff;

   // parser state
   logic [2:0]     phase_ff,   phase_in;
   logic [LW-1:0]  len_ff,     len_in;
   logic           hdr_ff,     hdr_in;
   logic [1:0]     fnum_ff,    fnum_in;
   logic [1:0]     fph_ff,     fph_in;
   logic [FVW-1:0] fval_ff,    fval_in;
   logic           neg_ff,     neg_in;
   logic           ovf_ff,     ovf_in;
   logic           bad_ff,     bad_in;
   logic [7:0]     red_ff,     red_in;
   logic [7:0]     green_ff,   green_in;
   logic [CW-1:0]  expect_ff,  expect_in;
   logic [CW-1:0]  done_ff,    done_in;

   // state as seen by this beat, after a start of file
   logic [2:0]     w_phase;
   logic [LW-1:0]  w_len;
   logic           w_hdr;
   logic [1:0]     w_fnum;
   logic [1:0]     w_fph;
   logic [FVW-1:0] w_fval;
   logic           w_neg;
   logic           w_ovf;
   logic           w_bad;
   logic [7:0]     w_red;
   logic [7:0]     w_green;
   logic [CW-1:0]  w_expect;
   logic [CW-1:0]  w_done;

   logic             adv;
   logic             res_valid;
   ptp_pkg::rsp_type res;

   logic [7:0]     c;
   logic           is_digit;
   logic           is_blank;
   logic           is_sign;
   logic [3:0]     dval;
   logic [PW-1:0]  mul_src;
   logic [PW-1:0]  prod;
   logic [PW-1:0]  limit;
   logic           prod_ovf;
   logic           fld_ok;
   logic           do_char;
   logic           do_end;
   logic           do_fail;
   logic           go_start;
   logic           line_ok;
   logic [2:0]     fail_st;
   logic [IXW-1:0] done_ext;
   logic           is_last;

   // pipeline handshake: the input stage drains whenever the result slot is free
   assign adv        = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_eoi_ff  <= req_tlast;
         in_sof_ff  <= req_tuser[0];
      end
   end

   // start of file behaves like a reset in front of this byte
   always_comb begin
      if (in_sof_ff) begin
         w_phase  = ptp_pkg::PH_SIG;
         w_len    = '0;
         w_hdr    = 1'b1;
         w_fnum   = 2'd0;
         w_fph    = ptp_pkg::FP_START;
         w_fval   = '0;
         w_neg    = 1'b0;
         w_ovf    = 1'b0;
         w_bad    = 1'b0;
         w_red    = '0;
         w_green  = '0;
         w_expect = '0;
         w_done   = '0;
      end else begin
         w_phase  = phase_ff;
         w_len    = len_ff;
         w_hdr    = hdr_ff;
         w_fnum   = fnum_ff;
         w_fph    = fph_ff;
         w_fval   = fval_ff;
         w_neg    = neg_ff;
         w_ovf    = ovf_ff;
         w_bad    = bad_ff;
         w_red    = red_ff;
         w_green  = green_ff;
         w_expect = expect_ff;
         w_done   = done_ff;
      end
   end

   // character classes and the multiply-by-ten step
   assign c        = in_byte_ff;
   assign is_digit = (c >= ptp_pkg::CH_ZERO) && (c <= ptp_pkg::CH_NINE);
   assign is_blank = (c == ptp_pkg::CH_SPACE) || (c == ptp_pkg::CH_TAB) ||
                     (c == ptp_pkg::CH_VT) || (c == ptp_pkg::CH_FF);
   assign is_sign  = (c == ptp_pkg::CH_PLUS) || (c == ptp_pkg::CH_MINUS);
   assign dval     = c[3:0];
   // the multiply source is the field value only in the digit phase
   assign mul_src  = (w_fph == ptp_pkg::FP_DIGITS) ? PW'(w_fval) : '0;
   assign prod     = (mul_src << 3) + (mul_src << 1) + PW'(dval);
   assign limit    = (w_phase == ptp_pkg::PH_COUNT) ? PW'(MAX_COLORS)
                                                    : PW'(ptp_pkg::CHANNEL_LIMIT);
   assign prod_ovf = prod > limit;
   // strtol value accepted: no overflow, and minus only on zero
   assign fld_ok   = !w_ovf && !(w_neg && (w_fval != '0));
   assign done_ext = IXW'(w_done);
   assign is_last  = ({1'b0, w_done} + 1'b1) == {1'b0, w_expect};

   always_comb begin
      phase_in  = w_phase;
      len_in    = w_len;
      hdr_in    = w_hdr;
      fnum_in   = w_fnum;
      fph_in    = w_fph;
      fval_in   = w_fval;
      neg_in    = w_neg;
      ovf_in    = w_ovf;
      bad_in    = w_bad;
      red_in    = w_red;
      green_in  = w_green;
      expect_in = w_expect;
      done_in   = w_done;
      res_valid = 1'b0;
      res       = '0;
      do_char   = 1'b0;
      do_end    = 1'b0;
      do_fail   = 1'b0;
      go_start  = 1'b0;
      line_ok   = 1'b0;
      fail_st   = ptp_pkg::ST_HDR_READ;

      // byte classification; nothing moves once done or halted
      if (w_phase <= ptp_pkg::PH_COLOR) begin
         if (in_eoi_ff || (c == ptp_pkg::CH_LF) || (c == ptp_pkg::CH_EOF)) begin
            do_end = 1'b1;
         end else if (c == ptp_pkg::CH_CR) begin
            do_end = 1'b0;
         end else if (c == ptp_pkg::CH_NUL) begin
            do_fail = 1'b1;
            fail_st = (w_phase == ptp_pkg::PH_COLOR) ? ptp_pkg::ST_BAD_CHANNEL
                                                     : ptp_pkg::ST_HDR_READ;
         end else if (w_len >= LW'(MAX_LINE_CHARS)) begin
            // an over-long color line is cut here, a header line fails
            if (w_phase == ptp_pkg::PH_COLOR) begin
               do_end = 1'b1;
            end else begin
               do_fail = 1'b1;
               fail_st = ptp_pkg::ST_HDR_READ;
            end
         end else begin
            do_char = 1'b1;
         end
      end

      // ordinary character
      if (do_char) begin
         case (w_phase)
            ptp_pkg::PH_SIG: begin
               if ((w_len >= LW'(ptp_pkg::SIG_LEN)) ||
                   (ptp_pkg::SIG_TEXT[w_len[2:0]] != c)) begin
                  hdr_in = 1'b0;
               end
            end
            ptp_pkg::PH_VER: begin
               if ((w_len >= LW'(ptp_pkg::VER_LEN)) ||
                   (ptp_pkg::VER_TEXT[w_len[1:0]] != c)) begin
                  hdr_in = 1'b0;
               end
            end
            default: begin
               // number fields: count line has one, color line three
               if (!w_bad && (w_fnum != ptp_pkg::FIELD_DONE)) begin
                  if (w_fph == ptp_pkg::FP_DIGITS) begin
                     if (is_digit) begin
                        fval_in = prod_ovf ? FVW'(limit) : FVW'(prod);
                        ovf_in  = w_ovf || prod_ovf;
                     end else if (!fld_ok) begin
                        bad_in = 1'b1;
                     end else if (((w_phase == ptp_pkg::PH_COUNT) && (w_fnum == 2'd0)) ||
                                  ((w_phase == ptp_pkg::PH_COLOR) && (w_fnum == 2'd2))) begin
                        fnum_in = ptp_pkg::FIELD_DONE;
                     end else begin
                        if (w_fnum == 2'd0) begin
                           red_in = w_fval[7:0];
                        end else begin
                           green_in = w_fval[7:0];
                        end
                        fnum_in  = w_fnum + 2'd1;
                        fval_in  = '0;
                        neg_in   = 1'b0;
                        ovf_in   = 1'b0;
                        fph_in   = ptp_pkg::FP_START;
                        go_start = 1'b1;
                     end
                  end else begin
                     go_start = 1'b1;
                  end
                  if (go_start) begin
                     if ((fph_in == ptp_pkg::FP_START) && is_blank) begin
                        go_start = 1'b1;
                     end else if ((fph_in == ptp_pkg::FP_START) && is_sign) begin
                        neg_in = neg_in || (c == ptp_pkg::CH_MINUS);
                        fph_in = ptp_pkg::FP_SIGN;
                     end else if (is_digit) begin
                        fval_in = prod_ovf ? FVW'(limit) : FVW'(prod);
                        ovf_in  = ovf_in || prod_ovf;
                        fph_in  = ptp_pkg::FP_DIGITS;
                     end else begin
                        bad_in = 1'b1;
                     end
                  end
               end
            end
         endcase
         len_in = w_len + 1'b1;
      end

      // end of line: judge the line, then clear the line state
      if (do_end) begin
         case (w_phase)
            ptp_pkg::PH_SIG: begin
               if (w_hdr && (w_len == LW'(ptp_pkg::SIG_LEN))) begin
                  phase_in = ptp_pkg::PH_VER;
               end else begin
                  do_fail = 1'b1;
                  fail_st = ptp_pkg::ST_BAD_SIG;
               end
            end
            ptp_pkg::PH_VER: begin
               if (w_hdr && (w_len == LW'(ptp_pkg::VER_LEN))) begin
                  phase_in = ptp_pkg::PH_COUNT;
               end else begin
                  do_fail = 1'b1;
                  fail_st = ptp_pkg::ST_BAD_VER;
               end
            end
            ptp_pkg::PH_COUNT: begin
               line_ok = !w_bad && ((w_fnum == ptp_pkg::FIELD_DONE) ||
                         ((w_fnum == 2'd0) && (w_fph == ptp_pkg::FP_DIGITS) && fld_ok));
               if (line_ok && (w_fval != '0) && (PW'(w_fval) <= PW'(MAX_COLORS))) begin
                  expect_in = CW'(w_fval);
                  done_in   = '0;
                  phase_in  = ptp_pkg::PH_COLOR;
               end else begin
                  do_fail = 1'b1;
                  fail_st = ptp_pkg::ST_BAD_COUNT;
               end
            end
            default: begin
               line_ok = !w_bad && ((w_fnum == ptp_pkg::FIELD_DONE) ||
                         ((w_fnum == 2'd2) && (w_fph == ptp_pkg::FP_DIGITS) && fld_ok));
               if (line_ok) begin
                  res_valid       = 1'b1;
                  res.status      = ptp_pkg::ST_COLOR;
                  res.color_index = done_ext[7:0];
                  res.red         = w_red;
                  res.green       = w_green;
                  res.blue        = w_fval[7:0];
                  res.last_color  = is_last;
                  done_in         = w_done + 1'b1;
                  if (is_last) begin
                     phase_in = ptp_pkg::PH_DONE;
                  end
               end else begin
                  do_fail = 1'b1;
                  fail_st = ptp_pkg::ST_BAD_CHANNEL;
               end
            end
         endcase
         len_in  = '0;
         hdr_in  = 1'b1;
         fnum_in = 2'd0;
         fph_in  = ptp_pkg::FP_START;
         fval_in = '0;
         neg_in  = 1'b0;
         ovf_in  = 1'b0;
         bad_in  = 1'b0;
      end

      // any error: one error beat, then halt until start of file
      if (do_fail) begin
         phase_in  = ptp_pkg::PH_HALT;
         res_valid = 1'b1;
         res       = '0;
         res.status = fail_st;
         if (fail_st == ptp_pkg::ST_BAD_CHANNEL) begin
            res.color_index = done_ext[7:0];
         end
      end
   end

   // parser control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= ptp_pkg::PH_SIG;
         len_ff    <= '0;
         hdr_ff    <= 1'b1;
         fnum_ff   <= 2'd0;
         fph_ff    <= ptp_pkg::FP_START;
         fval_ff   <= '0;
         neg_ff    <= 1'b0;
         ovf_ff    <= 1'b0;
         bad_ff    <= 1'b0;
         red_ff    <= '0;
         green_ff  <= '0;
         expect_ff <= '0;
         done_ff   <= '0;
      end else if (adv) begin
         phase_ff  <= phase_in;
         len_ff    <= len_in;
         hdr_ff    <= hdr_in;
         fnum_ff   <= fnum_in;
         fph_ff    <= fph_in;
         fval_ff   <= fval_in;
         neg_ff    <= neg_in;
         ovf_ff    <= ovf_in;
         bad_ff    <= bad_in;
         red_ff    <= red_in;
         green_ff  <= green_in;
         expect_ff <= expect_in;
         done_ff   <= done_in;
      end
   end

   // result register: valid follows every drained beat, data loads only with a result; emptied when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= res_valid;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.blue, rsp_ff.green, rsp_ff.red, rsp_ff.color_index};
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tlast  = rsp_ff.last_color;

   // line length never passes the line limit
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(MAX_LINE_CHARS))
      else $error("line length beyond limit");

   // while colors are pending, fewer than the declared count are done
   a_done_below: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == ptp_pkg::PH_COLOR) |-> (done_ff < expect_ff))
      else $error("color count passed declared count");

   // an error beat halts the parser
   a_err_halts: assert property (@(posedge clock) disable iff (reset)
      (adv && res_valid && (res.status != ptp_pkg::ST_COLOR)) |=>
      (phase_ff == ptp_pkg::PH_HALT))
      else $error("error beat without halt");

   // the last color and only it ends the palette
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (adv && res_valid && (res.status == ptp_pkg::ST_COLOR)) |=>
      ((phase_ff == ptp_pkg::PH_DONE) == $past(res.last_color)))
      else $error("last color and palette end disagree");

   // a channel value never exceeds a byte during color lines
   a_chan_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == ptp_pkg::PH_COLOR) |-> (PW'(fval_ff) <= PW'(ptp_pkg::CHANNEL_LIMIT)))
      else $error("channel value beyond limit");

endmodule

// ===== verif/palette_text_parser_test.sv =====
// self-checking testbench for the palette text parser against a byte-level predictor
`timescale 1ns / 100ps

module palette_text_parser_test;

   localparam int LINE_CHARS  = 15;
   localparam int PALETTE_MAX = 256;
   localparam int BYTE_GOAL   = 1350;
   // cycles with no beat on either side before the run is declared hung
   localparam int IDLE_LIMIT  = 2000;

   // one byte beat of a palette file as it goes to the parser
   typedef struct {
      logic [7:0] data;
      bit         eoi;
      bit         sof;
   } text_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] data_byte
   logic [0:0]  req_tuser = '0;   // [0] start_of_file
   logic        req_tlast = 1'b0; // end_of_input
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;       // [7:0] color_index, [15:8] red, [23:16] green, [31:24] blue
   logic [2:0]  rsp_tuser;       // [2:0] status
   logic        rsp_tlast;       // last_color

   text_beat_type     byte_backlog [$];  // file bytes not yet handed to the parser
   ptp_pkg::rsp_type  colors_due [$];    // predicted color and error beats, oldest first
   int          mismatches = 0;
   int          bytes_made = 0;
   int          quiet_cycles = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   bit          sof_pending = 1'b0;
   bit          counting = 1'b1;

   // predictor state, mirrors what the parser keeps between bytes
   logic [2:0] prs_phase;
   logic [3:0] line_len;
   logic       hdr_ok;
   logic [1:0] fld_num;
   logic [1:0] fld_stage;
   logic [8:0] fld_val;
   logic       fld_neg, fld_ovf, fld_bad;
   logic [7:0] red_keep, green_keep;
   logic [8:0] colors_total, colors_seen;

   palette_text_parser #(
      .MAX_LINE_CHARS(LINE_CHARS),
      .MAX_COLORS    (PALETTE_MAX)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_line();
      line_len  = '0;
      hdr_ok    = 1'b1;
      fld_num   = '0;
      fld_stage = ptp_pkg::FP_START;
      fld_val   = '0;
      fld_neg   = 1'b0;
      fld_ovf   = 1'b0;
      fld_bad   = 1'b0;
   endfunction

   function automatic void clear_parser();
      prs_phase = ptp_pkg::PH_SIG;
      clear_line();
      red_keep     = '0;
      green_keep   = '0;
      colors_total = '0;
      colors_seen  = '0;
   endfunction

   // decimal accumulate, clamping at the field's limit instead of wrapping
   function automatic void take_digit(logic [7:0] c, int unsigned cap);
      int unsigned v;
      v = fld_val * 10 + (c - ptp_pkg::CH_ZERO);
      if (v > cap) begin
         v = cap;
         fld_ovf = 1'b1;
      end
      fld_val = 9'(v);
   endfunction

   // a negative value is only legal as minus zero
   function automatic bit value_ok();
      return !fld_ovf && !(fld_neg && fld_val != 0);
   endfunction

   // one character of a count or color line, strtol style per field
   function automatic void field_char(logic [7:0] c, int unsigned cap, logic [1:0] last_fld);
      bit is_digit;
      is_digit = (c >= ptp_pkg::CH_ZERO && c <= ptp_pkg::CH_NINE);
      if (fld_bad || fld_num == ptp_pkg::FIELD_DONE) return;
      if (fld_stage == ptp_pkg::FP_DIGITS) begin
         if (is_digit) begin
            take_digit(c, cap);
            return;
         end
         if (!value_ok()) begin
            fld_bad = 1'b1;
            return;
         end
         if (fld_num == last_fld) begin
            fld_num = ptp_pkg::FIELD_DONE;
            return;
         end
         // a field closes on this character, which may open the next one
         if (fld_num == 0) red_keep = fld_val[7:0];
         else green_keep = fld_val[7:0];
         fld_num++;
         fld_val   = '0;
         fld_neg   = 1'b0;
         fld_ovf   = 1'b0;
         fld_bad   = 1'b0;
         fld_stage = ptp_pkg::FP_START;
      end
      if (fld_stage == ptp_pkg::FP_START) begin
         if (c == ptp_pkg::CH_SPACE || c == ptp_pkg::CH_TAB ||
             c == ptp_pkg::CH_VT || c == ptp_pkg::CH_FF) return;
         if (c == ptp_pkg::CH_PLUS || c == ptp_pkg::CH_MINUS) begin
            if (c == ptp_pkg::CH_MINUS) fld_neg = 1'b1;
            fld_stage = ptp_pkg::FP_SIGN;
            return;
         end
      end
      if (is_digit) begin
         fld_val = '0;
         take_digit(c, cap);
         fld_stage = ptp_pkg::FP_DIGITS;
      end else begin
         fld_bad = 1'b1;
      end
   endfunction

   // at line end: did the number fields come out complete and legal
   function automatic bit number_done(logic [1:0] last_fld);
      if (fld_bad) return 1'b0;
      if (fld_num == last_fld && fld_stage == ptp_pkg::FP_DIGITS) begin
         if (!value_ok()) return 1'b0;
         fld_num = ptp_pkg::FIELD_DONE;
      end
      return fld_num == ptp_pkg::FIELD_DONE;
   endfunction

   function automatic bit halt_with(logic [2:0] st, output ptp_pkg::rsp_type r);
      r = '0;
      r.status = st;
      r.color_index = (st == ptp_pkg::ST_BAD_CHANNEL) ? colors_seen[7:0] : 8'd0;
      prs_phase = ptp_pkg::PH_HALT;
      return 1'b1;
   endfunction

   function automatic bit close_line(output ptp_pkg::rsp_type r);
      bit emitted;
      emitted = 1'b0;
      r = '0;
      case (prs_phase)
         ptp_pkg::PH_SIG: begin
            if (hdr_ok && line_len == ptp_pkg::SIG_LEN) prs_phase = ptp_pkg::PH_VER;
            else emitted = halt_with(ptp_pkg::ST_BAD_SIG, r);
         end
         ptp_pkg::PH_VER: begin
            if (hdr_ok && line_len == ptp_pkg::VER_LEN) prs_phase = ptp_pkg::PH_COUNT;
            else emitted = halt_with(ptp_pkg::ST_BAD_VER, r);
         end
         ptp_pkg::PH_COUNT: begin
            if (number_done(2'd0) && fld_val >= 1 && fld_val <= PALETTE_MAX) begin
               colors_total = fld_val;
               colors_seen  = '0;
               prs_phase    = ptp_pkg::PH_COLOR;
            end else begin
               emitted = halt_with(ptp_pkg::ST_BAD_COUNT, r);
            end
         end
         default: begin
            if (number_done(2'd2)) begin
               r.status      = ptp_pkg::ST_COLOR;
               r.color_index = colors_seen[7:0];
               r.red         = red_keep;
               r.green       = green_keep;
               r.blue        = fld_val[7:0];
               r.last_color  = (colors_seen + 1 == colors_total);
               emitted = 1'b1;
               colors_seen++;
               if (colors_seen >= colors_total) prs_phase = ptp_pkg::PH_DONE;
            end else begin
               emitted = halt_with(ptp_pkg::ST_BAD_CHANNEL, r);
            end
         end
      endcase
      clear_line();
      return emitted;
   endfunction

   // advance the predictor by one accepted byte beat; 1 when a result beat is due
   function automatic bit predict_byte(logic [7:0] c, bit eoi, bit sof,
                                       output ptp_pkg::rsp_type r);
      r = '0;
      if (sof) clear_parser();
      if (prs_phase > ptp_pkg::PH_COLOR) return 1'b0;
      if (eoi || c == ptp_pkg::CH_LF || c == ptp_pkg::CH_EOF) return close_line(r);
      if (c == ptp_pkg::CH_CR) return 1'b0;
      if (c == ptp_pkg::CH_NUL)
         return halt_with(prs_phase == ptp_pkg::PH_COLOR ? ptp_pkg::ST_BAD_CHANNEL
                                                         : ptp_pkg::ST_HDR_READ, r);
      if (line_len >= LINE_CHARS) begin
         // an overlong color line is cut here, a header line is an error
         if (prs_phase == ptp_pkg::PH_COLOR) return close_line(r);
         return halt_with(ptp_pkg::ST_HDR_READ, r);
      end
      case (prs_phase)
         ptp_pkg::PH_SIG: begin
            if (line_len >= ptp_pkg::SIG_LEN || ptp_pkg::SIG_TEXT[line_len] != c)
               hdr_ok = 1'b0;
         end
         ptp_pkg::PH_VER: begin
            if (line_len >= ptp_pkg::VER_LEN || ptp_pkg::VER_TEXT[line_len] != c)
               hdr_ok = 1'b0;
         end
         ptp_pkg::PH_COUNT: field_char(c, PALETTE_MAX, 2'd0);
         default: field_char(c, ptp_pkg::CHANNEL_LIMIT, 2'd2);
      endcase
      line_len++;
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------- file generator

   task automatic put_beat(logic [7:0] data, bit eoi);
      text_beat_type b;
      b.data = data;
      b.eoi  = eoi;
      b.sof  = sof_pending;
      sof_pending = 1'b0;
      byte_backlog.push_back(b);
      if (counting) bytes_made++;
   endtask

   task automatic put_byte(logic [7:0] c);
      put_beat(c, 1'b0);
   endtask

   // end of input carries a random, ignored data byte
   task automatic put_eoi();
      put_beat(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic put_text(string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   function automatic logic [7:0] any_blank();
      case ($urandom_range(0, 3))
         0: return ptp_pkg::CH_SPACE;
         1: return ptp_pkg::CH_TAB;
         2: return ptp_pkg::CH_VT;
         default: return ptp_pkg::CH_FF;
      endcase
   endfunction

   // mostly line feeds, sometimes cr lf, the 0xff byte or end of input
   task automatic end_line();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 15) put_byte(ptp_pkg::CH_CR);
      if (pick < 70) put_byte(ptp_pkg::CH_LF);
      else if (pick < 85) put_byte(ptp_pkg::CH_EOF);
      else put_eoi();
   endtask

   // decimal text with optional blanks, sign and leading zero
   task automatic put_number(int unsigned v);
      int pick;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 2)) put_byte(any_blank());
      pick = $urandom_range(0, 99);
      if (pick < 4 || (v == 0 && pick < 30)) put_byte(ptp_pkg::CH_MINUS);
      else if (pick < 12) put_byte(ptp_pkg::CH_PLUS);
      if ($urandom_range(0, 9) == 0) put_byte(ptp_pkg::CH_ZERO);
      put_text($sformatf("%0d", v));
   endtask

   function automatic int unsigned channel_value();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 75) return $urandom_range(0, 255);
      if (pick < 85) return ptp_pkg::CHANNEL_LIMIT;
      if (pick < 92) return 0;
      if (pick < 97) return $urandom_range(ptp_pkg::CHANNEL_LIMIT + 1, 999);
      return 99999;
   endfunction

   // signature or version line, now and then damaged
   task automatic header_line(bit is_sig, output bit broken);
      logic [7:0] txt [$];
      int spot, target;
      broken = 1'b0;
      if (is_sig) for (int i = 0; i < ptp_pkg::SIG_LEN; i++) txt.push_back(ptp_pkg::SIG_TEXT[i]);
      else for (int i = 0; i < ptp_pkg::VER_LEN; i++) txt.push_back(ptp_pkg::VER_TEXT[i]);
      if ($urandom_range(0, 99) < 12) begin
         spot = $urandom_range(0, txt.size() - 1);
         broken = 1'b1;
         case ($urandom_range(0, 7))
            0: txt[spot] = 8'($urandom_range(33, 126));
            1: void'(txt.pop_back());
            2: txt.push_back(8'($urandom_range(33, 126)));
            3: begin
               // just below, right at or just past the length limit
               target = $urandom_range(LINE_CHARS - 1, LINE_CHARS + 3);
               while (txt.size() < target) txt.push_back(8'($urandom_range(33, 126)));
            end
            4: txt.insert(spot, ptp_pkg::CH_NUL);
            5: txt.delete();
            6: begin
               // a stray carriage return is dropped, so the line still matches
               txt.insert(spot, ptp_pkg::CH_CR);
               broken = 1'b0;
            end
            default: txt.insert(spot, 8'($urandom_range(0, 255)));
         endcase
      end
      foreach (txt[i]) put_byte(txt[i]);
      end_line();
   endtask

   // color count line; lines says how many color lines follow it
   task automatic count_line(output int lines);
      int pick;
      pick = $urandom_range(0, 99);
      lines = $urandom_range(1, 4);
      if (pick < 80) begin
         put_number(lines);
      end else begin
         case (pick - 80)
            0, 1: put_number(PALETTE_MAX);
            2: put_text("0");
            3: put_number(PALETTE_MAX + 1);
            4: put_text("99999");
            5: put_text("-0");
            6: ;
            7: put_text("x2");
            8: begin
               put_text("2x");
               lines = 2;
            end
            9: begin
               put_byte(ptp_pkg::CH_TAB);
               put_text("1");
               lines = 1;
            end
            10: put_text("-");
            11: begin
               put_text("00003");
               lines = 3;
            end
            default: put_number(lines);
         endcase
      end
      end_line();
   endtask

   task automatic colour_line();
      int shape;
      shape = $urandom_range(0, 99);
      if (shape < 3) begin
         // empty line
      end else if (shape < 5) begin
         put_byte(ptp_pkg::CH_NUL);
      end else begin
         for (int ch = 0; ch < 3; ch++) begin
            if (ch == 2 && shape < 8) break;
            // rarely no separator, so the digits run together
            if (ch > 0 && $urandom_range(0, 19) != 0)
               repeat ($urandom_range(1, 2)) put_byte(any_blank());
            put_number(channel_value());
         end
         if (shape < 14) begin
            put_byte(any_blank());
            put_byte(8'($urandom_range(33, 126)));
         end else if (shape < 17) begin
            put_byte(8'($urandom_range(0, 255)));
         end
      end
      end_line();
   endtask

   // one palette file from its first byte; a broken header or a random cut ends it early
   task automatic make_file();
      bit broken;
      int lines;
      sof_pending = 1'b1;
      header_line(1'b1, broken);
      if (broken) return;
      header_line(1'b0, broken);
      if (broken) return;
      count_line(lines);
      for (int i = 0; i < lines; i++) begin
         if ($urandom_range(0, 49) == 0) return;
         colour_line();
      end
      if ($urandom_range(0, 4) == 0) begin
         // trailing bytes after the palette are ignored
         counting = 1'b0;
         repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
         put_eoi();
         counting = 1'b1;
      end
   endtask

   // ---------------------------------------------------------------- driver and receiver

   // hands the next backlog byte to the parser once the current beat is taken
   always @(posedge clock) begin : drive_bytes
      text_beat_type b;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            b = byte_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= b.data;
            req_tuser  <= b.sof;
            req_tlast  <= b.eoi;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // ---------------------------------------------------------------- monitor

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // predicts on every accepted byte first, then checks any result beat of the same edge
   always @(posedge clock) begin : watch_beats
      ptp_pkg::rsp_type want;
      if (reset) begin
         clear_parser();
      end else begin
         if (req_tvalid && req_tready) begin
            if (predict_byte(req_tdata, req_tlast, req_tuser[0], want))
               colors_due.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (colors_due.size() == 0) begin
               $error("result beat with no color or error pending");
               mismatches++;
            end else begin
               want = colors_due.pop_front();
               check_field("status", 8'(want.status), 8'(rsp_tuser));
               check_field("color_index", want.color_index, rsp_tdata[7:0]);
               check_field("red", want.red, rsp_tdata[15:8]);
               check_field("green", want.green, rsp_tdata[23:16]);
               check_field("blue", want.blue, rsp_tdata[31:24]);
               check_field("last_color", 8'(want.last_color), 8'(rsp_tlast));
            end
         end
      end
   end

   // hang detection: no beat on either side for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // nul in the signature line
      sof_pending = 1'b1;
      put_byte(ptp_pkg::CH_NUL);
      // end of input on an empty signature line, then a byte while halted
      sof_pending = 1'b1;
      put_eoi();
      put_byte(ptp_pkg::CH_PLUS);
      // smallest good file: cr lf ending, one color with max, minus zero and plus sign
      sof_pending = 1'b1;
      for (int i = 0; i < ptp_pkg::SIG_LEN; i++) put_byte(ptp_pkg::SIG_TEXT[i]);
      put_byte(ptp_pkg::CH_CR);
      put_byte(ptp_pkg::CH_LF);
      for (int i = 0; i < ptp_pkg::VER_LEN; i++) put_byte(ptp_pkg::VER_TEXT[i]);
      put_byte(ptp_pkg::CH_LF);
      put_text("1");
      put_byte(ptp_pkg::CH_LF);
      put_text("255 -0 +9");
      put_byte(ptp_pkg::CH_EOF);

      // idling phases: none, sender idle, receiver stalls, both
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 79; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 79; end
            default: begin send_idle_pct = 26; stall_pct = 26; end
         endcase
         while (bytes_made < (p + 1) * BYTE_GOAL / 4) make_file();
         while (byte_backlog.size() != 0) @(posedge clock);
      end

      // drain: last byte taken and every predicted beat seen
      while (byte_backlog.size() != 0 || req_tvalid || colors_due.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
